FILE: src/b2a_pkg.sv
// Shared constants and the character encoder for the binary to ASCII converter.
package b2a_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int NIB_W          = 4;
  localparam int CHAR_W         = 7;

  localparam logic [NIB_W-1:0]  BCD_ADJ_LIMIT = 4'd5;
  localparam logic [NIB_W-1:0]  BCD_ADJ       = 4'd3;
  localparam logic [NIB_W-1:0]  NIB_NINE      = 4'h9;
  localparam logic [CHAR_W-1:0] ASCII_ZERO    = 7'h30;
  localparam logic [CHAR_W-1:0] ASCII_AT      = 7'h40;

  // Digits 0 to 9 map onto '0'..'9'; ten to fifteen onto 'A'..'F'.
  function automatic logic [CHAR_W-1:0] hex_char(input logic [NIB_W-1:0] nib);
    logic [NIB_W-1:0] ofs;
    ofs = nib - NIB_NINE;
    if (nib <= NIB_NINE) begin
      return ASCII_ZERO + {{(CHAR_W-NIB_W){1'b0}}, nib};
    end else begin
      return ASCII_AT + {{(CHAR_W-NIB_W){1'b0}}, ofs};
    end
  endfunction

endpackage

FILE: src/b2a_dabble_step.sv
// One shift-and-add-three step of the bit-serial binary to BCD conversion.
module b2a_dabble_step #(
  parameter int DIGITS = 10
) (
  input  logic [DIGITS*b2a_pkg::NIB_W-1:0] bcd_i,
  input  logic                             bit_i,
  output logic [DIGITS*b2a_pkg::NIB_W-1:0] bcd_o
);

  localparam int W = DIGITS * b2a_pkg::NIB_W;

  logic [W-1:0] adj;

  for (genvar g = 0; g < DIGITS; g++) begin : g_digit
    logic [b2a_pkg::NIB_W-1:0] d;
    assign d = bcd_i[g*b2a_pkg::NIB_W +: b2a_pkg::NIB_W];
    assign adj[g*b2a_pkg::NIB_W +: b2a_pkg::NIB_W] =
        (d >= b2a_pkg::BCD_ADJ_LIMIT) ? d + b2a_pkg::BCD_ADJ : d;
  end

  assign bcd_o = {adj[W-2:0], bit_i};

endmodule

FILE: src/binary_to_ascii_digits.sv
// Top level: converts a binary value into a stream of ASCII decimal or hex characters.
// Decimal: the request is accepted, VALUE_BITS conversion steps run, leading zeros are
// skipped silently one digit slot at a time, and the skip is left before emission begins.
// Hex: the request is accepted and then the HEX_CHARS characters are emitted.
// Characters appear one per cycle on out_strobe; the receiver cannot stall them.
// Synchronous active-low reset returns the sequencer to idle with no strobe pending.
module binary_to_ascii_digits #(
  parameter int VALUE_BITS = b2a_pkg::VALUE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_action,
  input  logic [VALUE_BITS-1:0]       in_value,
  output logic                        out_strobe,
  output logic [b2a_pkg::CHAR_W-1:0]  out_ascii_char,
  output logic                        out_last
);

  localparam int DEC_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int HEX_CHARS  = (VALUE_BITS + 3) / 4;
  localparam int DIG_W      = DEC_DIGITS * b2a_pkg::NIB_W;
  localparam int HEX_W      = HEX_CHARS * b2a_pkg::NIB_W;
  localparam int CNT_W      = $clog2(VALUE_BITS + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_SKIP, ST_EMIT} state_t;

  state_t                       state_r, state_nxt;
  logic [VALUE_BITS-1:0]        val_r, val_nxt;
  logic [DIG_W-1:0]             dig_r, dig_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic                         strobe_r, strobe_nxt;
  logic [b2a_pkg::CHAR_W-1:0]   char_r, char_nxt;
  logic                         last_r, last_nxt;
  logic [DIG_W-1:0]             dig_step;
  logic [b2a_pkg::NIB_W-1:0]    top_nib;

  b2a_dabble_step #(.DIGITS(DEC_DIGITS)) u_step (
    .bcd_i (dig_r),
    .bit_i (val_r[VALUE_BITS-1]),
    .bcd_o (dig_step)
  );

  assign top_nib = dig_r[DIG_W-1 -: b2a_pkg::NIB_W];

  always_comb begin
    state_nxt  = state_r;
    val_nxt    = val_r;
    dig_nxt    = dig_r;
    cnt_nxt    = cnt_r;
    strobe_nxt = 1'b0;
    char_nxt   = char_r;
    last_nxt   = last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          val_nxt = in_value;
          dig_nxt = '0;
          if (in_action) begin
            // Hex characters are taken straight from the value, top nibble first.
            dig_nxt[DIG_W-1 -: HEX_W] = HEX_W'(in_value);
            cnt_nxt   = CNT_W'(HEX_CHARS);
            state_nxt = ST_EMIT;
          end else begin
            cnt_nxt   = CNT_W'(VALUE_BITS);
            state_nxt = ST_CONV;
          end
        end
      end
      ST_CONV: begin
        dig_nxt = dig_step;
        val_nxt = {val_r[VALUE_BITS-2:0], 1'b0};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          cnt_nxt   = CNT_W'(DEC_DIGITS);
          state_nxt = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // The last digit is always kept, so that zero still gives one character.
        if (top_nib == '0 && cnt_r != CNT_W'(1)) begin
          dig_nxt = {dig_r[DIG_W-b2a_pkg::NIB_W-1:0], {b2a_pkg::NIB_W{1'b0}}};
          cnt_nxt = cnt_r - CNT_W'(1);
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        strobe_nxt = 1'b1;
        char_nxt   = b2a_pkg::hex_char(top_nib);
        last_nxt   = (cnt_r == CNT_W'(1));
        dig_nxt    = {dig_r[DIG_W-b2a_pkg::NIB_W-1:0], {b2a_pkg::NIB_W{1'b0}}};
        cnt_nxt    = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
    val_r  <= val_nxt;
    dig_r  <= dig_nxt;
    cnt_r  <= cnt_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

  assign busy           = (state_r != ST_IDLE);
  assign out_strobe     = strobe_r;
  assign out_ascii_char = char_r;
  assign out_last       = last_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("request accepted but converter not busy");

  a_strobe_in_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("character strobed outside a request");

  // A new request may be taken while the last character is out, so only the strobe must stop.
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_last |-> !busy ##1 !out_strobe)
    else $error("characters continue after the last one");

  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_ascii_char >= 7'h30 && out_ascii_char <= 7'h39) ||
                   (out_ascii_char >= 7'h41 && out_ascii_char <= 7'h46))
    else $error("character outside the digit set");

endmodule
